/* hdl/offset_range_translation_table_core_defines.svh */
// assertion macros shared by the translation table rtl
`ifndef OFFSET_RANGE_TRANSLATION_TABLE_CORE_DEFINES_SVH
`define OFFSET_RANGE_TRANSLATION_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define ORTT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ortt assertion failed");

// next-cycle implication
`define ORTT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ortt assertion failed");

`endif

/* hdl/ortt_pkg.sv */
// shared constants, codes and controller/datapath signal groups
package ortt_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int OFFSET_BITS  = 32;
   localparam int MAP_BITS     = OFFSET_BITS + 1;
   localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_BITS     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int ACT_BITS     = 3;
   localparam int STS_BITS     = 2;

   localparam logic [ACT_BITS-1:0] ACT_INSERT  = 3'd0;
   localparam logic [ACT_BITS-1:0] ACT_MAP     = 3'd1;
   localparam logic [ACT_BITS-1:0] ACT_RANGE   = 3'd2;
   localparam logic [ACT_BITS-1:0] ACT_REVERSE = 3'd3;
   localparam logic [ACT_BITS-1:0] ACT_CLEAR   = 3'd4;

   localparam logic [STS_BITS-1:0] ST_OK     = 2'd0;
   localparam logic [STS_BITS-1:0] ST_REJECT = 2'd1;
   localparam logic [STS_BITS-1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan_init;
      logic scan_step;
      logic sum;
      logic form;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic                is_scan;
      logic                scan_done;
      logic [CNT_BITS-1:0] seg_count;
   } dp_sts_type;

endpackage

/* hdl/ortt_if.sv */
// request and response channel interfaces
interface ortt_req_if import ortt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ACT_BITS-1:0]    action;
   logic [OFFSET_BITS-1:0] first_offset;
   logic                   first_valid;
   logic [OFFSET_BITS-1:0] second_offset;
   logic                   second_valid;
   logic [OFFSET_BITS-1:0] document_offset;
   logic                   document_valid;

   modport source (output valid, action, first_offset, first_valid, second_offset,
                   second_valid, document_offset, document_valid, input ready);
   modport sink   (input valid, action, first_offset, first_valid, second_offset,
                   second_valid, document_offset, document_valid, output ready);
endinterface

interface ortt_rsp_if import ortt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STS_BITS-1:0] status;
   logic [MAP_BITS-1:0] mapped_start;
   logic [MAP_BITS-1:0] mapped_end;

   modport source (output valid, status, mapped_start, mapped_end, input ready);
   modport sink   (input valid, status, mapped_start, mapped_end, output ready);
endinterface

/* hdl/ortt_ctrl.sv */
// sequencing state machine for the translation table
module ortt_ctrl import ortt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  dp_sts_type dp_sts,
   output dp_cmd_type dp_cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SUM,
      S_FORM,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      dp_cmd   = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (dp_sts.is_scan) begin
               dp_cmd.scan_init = 1'b1;
               state_in         = S_SCAN;
            end else begin
               dp_cmd.exec = 1'b1;
               state_in    = S_OUT;
            end
         end
         S_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            if (dp_sts.scan_done) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            dp_cmd.sum = 1'b1;
            state_in   = S_FORM;
         end
         S_FORM: begin
            dp_cmd.form = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // wait for the output slot to free up
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.out_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/ortt_dp.sv */
// segment store, scan compare lanes and result registers
module ortt_dp import ortt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             dp_cmd,
   output dp_sts_type             dp_sts,
   input  logic [ACT_BITS-1:0]    action,
   input  logic [OFFSET_BITS-1:0] first_offset,
   input  logic                   first_valid,
   input  logic [OFFSET_BITS-1:0] second_offset,
   input  logic                   second_valid,
   input  logic [OFFSET_BITS-1:0] document_offset,
   input  logic                   document_valid,
   output logic [STS_BITS-1:0]    rsp_status,
   output logic [MAP_BITS-1:0]    rsp_mapped_start,
   output logic [MAP_BITS-1:0]    rsp_mapped_end
);

   typedef struct packed {
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] base;
      logic [OFFSET_BITS-1:0] len;
   } seg_type;

   // latched request beat
   logic [ACT_BITS-1:0]    act_ff;
   logic [OFFSET_BITS-1:0] a_ff, b_ff, d_ff;
   logic                   a_ok_ff, b_ok_ff, d_ok_ff;

   seg_type             seg_mem_ff [MAX_SEGMENTS];
   seg_type             rd_data_ff;
   seg_type             wr_data;
   logic                wr_en;
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic [CNT_BITS-1:0] issue_ff;
   logic                cmp_vld_ff;
   logic                hit_a_ff, hit_b_ff;
   logic [OFFSET_BITS-1:0] oth_a_ff, diff_a_ff, oth_b_ff, diff_b_ff;
   logic [MAP_BITS-1:0]    sum_a_ff, sum_b_ff;

   logic [STS_BITS-1:0] res_status_ff;
   logic [MAP_BITS-1:0] res_start_ff, res_end_ff;

   logic                   fwd;
   logic                   ins_empty, ins_full;
   logic [OFFSET_BITS-1:0] lo, oth, ofs_a, diff_a, diff_b;
   logic                   hit_a_now, hit_b_now;
   logic                   exhausted, need_b;
   logic [STS_BITS-1:0]    exec_status, form_status;
   logic [MAP_BITS-1:0]    form_start, form_end;

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         act_ff  <= action;
         a_ff    <= first_offset;
         a_ok_ff <= first_valid;
         b_ff    <= second_offset;
         b_ok_ff <= second_valid;
         d_ff    <= document_offset;
         d_ok_ff <= document_valid;
      end
   end

   // insert / clear
   always_comb begin
      ins_empty     = (b_ff <= a_ff) || !d_ok_ff;
      ins_full      = (count_ff >= CNT_BITS'(MAX_SEGMENTS));
      wr_en         = dp_cmd.exec && (act_ff == ACT_INSERT) && !ins_empty && !ins_full;
      wr_data.start = a_ff;
      wr_data.base  = d_ff;
      wr_data.len   = b_ff - a_ff;

      count_in = count_ff;
      if (dp_cmd.exec && (act_ff == ACT_CLEAR)) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_BITS'(1);
      end

      priority if (act_ff == ACT_INSERT) begin
         exec_status = ins_empty ? ST_REJECT : (ins_full ? ST_FULL : ST_OK);
      end else if (act_ff == ACT_CLEAR) begin
         exec_status = ST_OK;
      end else begin
         exec_status = ST_REJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seg_mem_ff[count_ff[IDX_BITS-1:0]] <= wr_data;
      end
      rd_data_ff <= seg_mem_ff[issue_ff[IDX_BITS-1:0]];
   end

   // compare lanes: lane a is the forward or reverse key, lane b the range end
   always_comb begin
      fwd    = (act_ff != ACT_REVERSE);
      lo     = fwd ? rd_data_ff.start : rd_data_ff.base;
      oth    = fwd ? rd_data_ff.base  : rd_data_ff.start;
      ofs_a  = fwd ? a_ff : d_ff;
      diff_a = ofs_a - lo;
      diff_b = b_ff - rd_data_ff.start;
      hit_a_now = (ofs_a >= lo) &&
                  (fwd ? (diff_a <= rd_data_ff.len) : (diff_a < rd_data_ff.len));
      hit_b_now = (b_ff >= rd_data_ff.start) && (diff_b <= rd_data_ff.len);

      need_b    = (act_ff == ACT_RANGE);
      exhausted = (issue_ff == count_ff) && !cmp_vld_ff;

      dp_sts.is_scan   = (act_ff == ACT_MAP) || (act_ff == ACT_RANGE) ||
                         (act_ff == ACT_REVERSE);
      dp_sts.scan_done = exhausted || (hit_a_ff && (!need_b || hit_b_ff));
      dp_sts.seg_count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         issue_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         hit_a_ff   <= 1'b0;
         hit_b_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (dp_cmd.scan_init) begin
            issue_ff   <= '0;
            cmp_vld_ff <= 1'b0;
            hit_a_ff   <= 1'b0;
            hit_b_ff   <= 1'b0;
         end else if (dp_cmd.scan_step) begin
            cmp_vld_ff <= (issue_ff < count_ff);
            if (issue_ff < count_ff) begin
               issue_ff <= issue_ff + CNT_BITS'(1);
            end
            // keep the first hit in insert order
            if (cmp_vld_ff && !hit_a_ff && hit_a_now) begin
               hit_a_ff <= 1'b1;
            end
            if (cmp_vld_ff && !hit_b_ff && hit_b_now) begin
               hit_b_ff <= 1'b1;
            end
         end else begin
            cmp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.scan_step && cmp_vld_ff && !hit_a_ff && hit_a_now) begin
         oth_a_ff  <= oth;
         diff_a_ff <= diff_a;
      end
      if (dp_cmd.scan_step && cmp_vld_ff && !hit_b_ff && hit_b_now) begin
         oth_b_ff  <= rd_data_ff.base;
         diff_b_ff <= diff_b;
      end
      if (dp_cmd.sum) begin
         sum_a_ff <= {1'b0, oth_a_ff} + {1'b0, diff_a_ff};
         sum_b_ff <= {1'b0, oth_b_ff} + {1'b0, diff_b_ff};
      end
   end

   always_comb begin
      form_status = ST_REJECT;
      form_start  = '0;
      form_end    = '0;
      unique case (act_ff)
         ACT_MAP: begin
            if (a_ok_ff && hit_a_ff) begin
               form_status = ST_OK;
               form_start  = sum_a_ff;
            end
         end
         ACT_RANGE: begin
            if (a_ok_ff && b_ok_ff && hit_a_ff && hit_b_ff && (sum_b_ff >= sum_a_ff)) begin
               form_status = ST_OK;
               form_start  = sum_a_ff;
               form_end    = sum_b_ff;
            end
         end
         ACT_REVERSE: begin
            if (hit_a_ff) begin
               form_status = ST_OK;
               form_start  = sum_a_ff;
            end
         end
         default: form_status = ST_REJECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         res_status_ff <= exec_status;
         res_start_ff  <= '0;
         res_end_ff    <= '0;
      end else if (dp_cmd.form) begin
         res_status_ff <= form_status;
         res_start_ff  <= form_start;
         res_end_ff    <= form_end;
      end
      if (dp_cmd.out_load) begin
         rsp_status       <= res_status_ff;
         rsp_mapped_start <= res_start_ff;
         rsp_mapped_end   <= res_end_ff;
      end
   end

endmodule

/* hdl/offset_range_translation_table_core.sv */
// insert, clear and unknown actions: the result register is written, then the output register
// lookups: one stored segment read per cycle on the single read port of the segment memory,
//   then sum, form and output load; a hit (on both lanes for a range) ends the scan early
// throughput: one request at a time; ready returns once the result is in the output register
// reset clears the segment count and all control state; segment contents stay undefined
`include "offset_range_translation_table_core_defines.svh"
module offset_range_translation_table_core import ortt_pkg::*; (
   input logic        clock,
   input logic        reset,
   ortt_req_if.sink   req_chan,
   ortt_rsp_if.source rsp_chan
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   ortt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_sts    (dp_sts),
      .dp_cmd    (dp_cmd)
   );

   ortt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_sts           (dp_sts),
      .action           (req_chan.action),
      .first_offset     (req_chan.first_offset),
      .first_valid      (req_chan.first_valid),
      .second_offset    (req_chan.second_offset),
      .second_valid     (req_chan.second_valid),
      .document_offset  (req_chan.document_offset),
      .document_valid   (req_chan.document_valid),
      .rsp_status       (rsp_chan.status),
      .rsp_mapped_start (rsp_chan.mapped_start),
      .rsp_mapped_end   (rsp_chan.mapped_end)
   );

   `ORTT_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   `ORTT_ASSERT_NOW(a_load_into_free_slot, dp_cmd.out_load, !rsp_chan.valid || rsp_chan.ready)
   `ORTT_ASSERT_NEXT(a_load_shows_beat, dp_cmd.out_load, rsp_chan.valid)
   `ORTT_ASSERT_NOW(a_count_bounded, 1'b1, dp_sts.seg_count <= CNT_BITS'(MAX_SEGMENTS))

endmodule

/* tb/offset_range_translation_table_core_tb.sv */
// self-checking testbench for the offset range translation table core
module offset_range_translation_table_core_tb;
   import ortt_pkg::*;

   localparam int unsigned ACT_TOP      = (1 << ACT_BITS) - 1;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES = MAX_SEGMENTS + 24;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned RANDOM_ITEMS = 1430;

   typedef struct packed {
      logic [ACT_BITS-1:0]    action;
      logic [OFFSET_BITS-1:0] first_offset;
      logic                   first_valid;
      logic [OFFSET_BITS-1:0] second_offset;
      logic                   second_valid;
      logic [OFFSET_BITS-1:0] document_offset;
      logic                   document_valid;
   } xlate_req_type;

   typedef struct packed {
      logic [STS_BITS-1:0] status;
      logic [MAP_BITS-1:0] mapped_start;
      logic [MAP_BITS-1:0] mapped_end;
   } xlate_rsp_type;

   class xlate_scoreboard_type;
      logic [OFFSET_BITS-1:0] seg_lo   [MAX_SEGMENTS];
      logic [OFFSET_BITS-1:0] seg_hi   [MAX_SEGMENTS];
      logic [OFFSET_BITS-1:0] seg_base [MAX_SEGMENTS];
      int unsigned            seg_used;
      xlate_rsp_type          expected_q [$];
      int unsigned            requests, checked, errors, full_count;
      int unsigned            ok_count [ACT_TOP+1];

      function new();
         seg_used   = 0;
         requests   = 0;
         checked    = 0;
         errors     = 0;
         full_count = 0;
         foreach (ok_count[i]) ok_count[i] = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // first segment in insert order whose local range holds ofs, end inclusive
      function bit find_local(logic [OFFSET_BITS-1:0] ofs, output logic [MAP_BITS-1:0] mapped);
         logic [OFFSET_BITS-1:0] gap;
         mapped = '0;
         for (int unsigned i = 0; i < seg_used; i++) begin
            if (ofs >= seg_lo[i] && ofs <= seg_hi[i]) begin
               gap    = ofs - seg_lo[i];
               mapped = {1'b0, seg_base[i]} + {1'b0, gap};
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // document window is base up to base + length, end exclusive
      function bit find_document(logic [OFFSET_BITS-1:0] ofs, output logic [MAP_BITS-1:0] mapped);
         logic [OFFSET_BITS-1:0] span, gap;
         logic [MAP_BITS-1:0]    top;
         mapped = '0;
         for (int unsigned i = 0; i < seg_used; i++) begin
            span = seg_hi[i] - seg_lo[i];
            top  = {1'b0, seg_base[i]} + {1'b0, span};
            if ({1'b0, ofs} >= {1'b0, seg_base[i]} && {1'b0, ofs} < top) begin
               gap    = ofs - seg_base[i];
               mapped = {1'b0, seg_lo[i]} + {1'b0, gap};
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(xlate_req_type it);
         xlate_rsp_type       want;
         logic [MAP_BITS-1:0] s, e;
         want.status       = ST_REJECT;
         want.mapped_start = '0;
         want.mapped_end   = '0;
         requests++;
         case (it.action)
            ACT_INSERT: begin
               // empty or baseless segments are refused before the full check
               if (it.second_offset <= it.first_offset || !it.document_valid) begin
                  want.status = ST_REJECT;
               end else if (seg_used >= MAX_SEGMENTS) begin
                  want.status = ST_FULL;
                  full_count++;
               end else begin
                  seg_lo[seg_used]   = it.first_offset;
                  seg_hi[seg_used]   = it.second_offset;
                  seg_base[seg_used] = it.document_offset;
                  seg_used++;
                  want.status = ST_OK;
               end
            end
            ACT_MAP: begin
               if (it.first_valid && find_local(it.first_offset, s)) begin
                  want.status       = ST_OK;
                  want.mapped_start = s;
               end
            end
            ACT_RANGE: begin
               if (it.first_valid && it.second_valid && find_local(it.first_offset, s)
                   && find_local(it.second_offset, e) && e >= s) begin
                  want.status       = ST_OK;
                  want.mapped_start = s;
                  want.mapped_end   = e;
               end
            end
            ACT_REVERSE: begin
               if (find_document(it.document_offset, s)) begin
                  want.status       = ST_OK;
                  want.mapped_start = s;
               end
            end
            ACT_CLEAR: begin
               seg_used    = 0;
               want.status = ST_OK;
            end
            default: want.status = ST_REJECT;
         endcase
         if (want.status == ST_OK) ok_count[it.action]++;
         expected_q = {expected_q, want};
      endfunction

      function void check_result(xlate_rsp_type got);
         xlate_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing outstanding: status %0d start %h end %h",
                   got.status, got.mapped_start, got.mapped_end);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            errors++;
         end
         if (got.mapped_start !== want.mapped_start) begin
            $error("mapped_start: expected %h actual %h", want.mapped_start, got.mapped_start);
            errors++;
         end
         if (got.mapped_end !== want.mapped_end) begin
            $error("mapped_end: expected %h actual %h", want.mapped_end, got.mapped_end);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ortt_req_if req_chan ();
   ortt_rsp_if rsp_chan ();

   offset_range_translation_table_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   xlate_scoreboard_type board = new();

   int unsigned send_idle_pct   = 0;
   int unsigned recv_idle_pct   = 0;
   int unsigned rsp_hold_cycles = 0;

   // segments the stimulus has offered since its last clear, used to aim lookups
   logic [OFFSET_BITS-1:0] gen_lo   [MAX_SEGMENTS];
   logic [OFFSET_BITS-1:0] gen_hi   [MAX_SEGMENTS];
   logic [OFFSET_BITS-1:0] gen_base [MAX_SEGMENTS];
   int unsigned            gen_n = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic xlate_req_type make_req(logic [ACT_BITS-1:0] act,
                                              logic [OFFSET_BITS-1:0] a, logic av,
                                              logic [OFFSET_BITS-1:0] b, logic bv,
                                              logic [OFFSET_BITS-1:0] d, logic dv);
      xlate_req_type it;
      it.action          = act;
      it.first_offset    = a;
      it.first_valid     = av;
      it.second_offset   = b;
      it.second_valid    = bv;
      it.document_offset = d;
      it.document_valid  = dv;
      return it;
   endfunction

   function automatic xlate_req_type random_fields();
      return make_req(ACT_BITS'($urandom_range(ACT_TOP)), $urandom(), 1'($urandom_range(1)),
                      $urandom(), 1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
   endfunction

   function automatic xlate_req_type next_insert();
      xlate_req_type          it;
      logic [OFFSET_BITS-1:0] span;
      it        = random_fields();
      it.action = ACT_INSERT;
      it.first_offset = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(8191);
      span = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(300, 1);
      case ($urandom_range(19))
         0:       it.second_offset = it.first_offset;
         1:       it.second_offset = it.first_offset - $urandom_range(50, 1);
         default: it.second_offset = it.first_offset + span;
      endcase
      case ($urandom_range(3))
         0:       it.document_offset = '1 - $urandom_range(1023);
         1:       it.document_offset = $urandom();
         default: it.document_offset = $urandom_range(1 << 20);
      endcase
      it.document_valid = ($urandom_range(11) != 0);
      if (it.second_offset > it.first_offset && it.document_valid && gen_n < MAX_SEGMENTS) begin
         gen_lo[gen_n]   = it.first_offset;
         gen_hi[gen_n]   = it.second_offset;
         gen_base[gen_n] = it.document_offset;
         gen_n++;
      end
      return it;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] near_local();
      int unsigned k;
      if (gen_n == 0 || $urandom_range(7) == 0) begin
         return $urandom_range(1) ? $urandom() : $urandom_range(8191);
      end
      k = $urandom_range(gen_n - 1);
      case ($urandom_range(7))
         0:       return gen_lo[k];
         1:       return gen_hi[k];
         2:       return gen_hi[k] + 1;
         3:       return gen_lo[k] - 1;
         default: return gen_lo[k] + $urandom_range(gen_hi[k] - gen_lo[k]);
      endcase
   endfunction

   function automatic logic [OFFSET_BITS-1:0] near_document();
      int unsigned            k;
      logic [OFFSET_BITS-1:0] span;
      if (gen_n == 0 || $urandom_range(7) == 0) return $urandom();
      k    = $urandom_range(gen_n - 1);
      span = gen_hi[k] - gen_lo[k];
      case ($urandom_range(7))
         0:       return gen_base[k];
         1:       return gen_base[k] + span - 1;
         2:       return gen_base[k] + span;
         3:       return gen_base[k] - 1;
         default: return gen_base[k] + $urandom_range(span - 1);
      endcase
   endfunction

   function automatic xlate_req_type next_mixed();
      xlate_req_type it;
      int unsigned   pick;
      it   = random_fields();
      pick = $urandom_range(99);
      if (pick < 18) begin
         it = next_insert();
      end else if (pick < 45) begin
         it.action       = ACT_MAP;
         it.first_offset = near_local();
         it.first_valid  = ($urandom_range(15) != 0);
      end else if (pick < 70) begin
         it.action        = ACT_RANGE;
         it.first_offset  = near_local();
         it.second_offset = ($urandom_range(3) == 0) ? near_local()
                                                      : it.first_offset + $urandom_range(64);
         it.first_valid   = ($urandom_range(15) != 0);
         it.second_valid  = ($urandom_range(15) != 0);
      end else if (pick < 94) begin
         it.action          = ACT_REVERSE;
         it.document_offset = near_document();
      end else if (pick < 97) begin
         it.action = ACT_CLEAR;
         gen_n     = 0;
      end else begin
         it.action = ACT_BITS'($urandom_range(ACT_TOP, ACT_CLEAR + 1));
      end
      return it;
   endfunction

   task automatic send_item(xlate_req_type it);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.action          <= it.action;
      req_chan.first_offset    <= it.first_offset;
      req_chan.first_valid     <= it.first_valid;
      req_chan.second_offset   <= it.second_offset;
      req_chan.second_valid    <= it.second_valid;
      req_chan.document_offset <= it.document_offset;
      req_chan.document_valid  <= it.document_valid;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_request(it);
   endtask

   task automatic run_directed();
      // empty table: lookups miss
      send_item(make_req(ACT_MAP, '0, 1'b1, '0, 1'b0, '0, 1'b0));
      send_item(make_req(ACT_REVERSE, '0, 1'b0, '0, 1'b0, '0, 1'b0));
      // empty range, end below start, missing base
      send_item(make_req(ACT_INSERT, 32'd100, 1'b0, 32'd100, 1'b0, 32'd5, 1'b1));
      send_item(make_req(ACT_INSERT, 32'd200, 1'b0, 32'd100, 1'b0, 32'd5, 1'b1));
      send_item(make_req(ACT_INSERT, '0, 1'b1, 32'd50, 1'b1, 32'd7, 1'b0));
      // widest segment at the highest base gives the largest sums
      send_item(make_req(ACT_INSERT, '0, 1'b1, '1, 1'b1, '1, 1'b1));
      send_item(make_req(ACT_MAP, '1, 1'b1, '0, 1'b0, '0, 1'b0));
      send_item(make_req(ACT_MAP, 32'd9, 1'b0, '0, 1'b1, '0, 1'b1));
      send_item(make_req(ACT_RANGE, '0, 1'b1, '1, 1'b1, '0, 1'b0));
      send_item(make_req(ACT_RANGE, 32'd5, 1'b1, 32'd9, 1'b0, '0, 1'b0));
      send_item(make_req(ACT_RANGE, 32'd5, 1'b0, 32'd9, 1'b1, '0, 1'b0));
      send_item(make_req(ACT_RANGE, 32'd10, 1'b1, 32'd5, 1'b1, '0, 1'b0));
      // reverse map ignores every valid bit
      send_item(make_req(ACT_REVERSE, '1, 1'b0, '1, 1'b0, '1, 1'b0));
      send_item(make_req(ACT_REVERSE, '0, 1'b1, '0, 1'b1, 32'hFFFF_FFFE, 1'b1));
      // second segment overlaps the first, so forward hits stay on the first
      send_item(make_req(ACT_INSERT, 32'd16, 1'b0, 32'd31, 1'b0, '0, 1'b1));
      send_item(make_req(ACT_REVERSE, '0, 1'b0, '0, 1'b0, 32'd14, 1'b1));
      send_item(make_req(ACT_REVERSE, '0, 1'b0, '0, 1'b0, 32'd15, 1'b0));
      send_item(make_req(ACT_MAP, 32'd20, 1'b1, '0, 1'b0, '0, 1'b0));
      send_item(make_req(ACT_CLEAR, '1, 1'b1, '1, 1'b1, '1, 1'b1));
      send_item(make_req(ACT_MAP, 32'd20, 1'b1, '0, 1'b0, '0, 1'b0));
      for (int unsigned a = ACT_CLEAR + 1; a <= ACT_TOP; a++) begin
         send_item(make_req(ACT_BITS'(a), '1, 1'b1, '1, 1'b1, '1, 1'b1));
      end
   endtask

   // each pass: clear, a burst of inserts, then mixed traffic aimed at the table
   task automatic run_random(int unsigned count, bit fill_first);
      int unsigned   sent, fill, mix;
      xlate_req_type it;
      sent = 0;
      while (sent < count) begin
         it        = random_fields();
         it.action = ACT_CLEAR;
         gen_n     = 0;
         send_item(it);
         if (fill_first && sent == 0) begin
            fill = MAX_SEGMENTS + 4;
         end else if ($urandom_range(4) == 0) begin
            fill = $urandom_range(MAX_SEGMENTS + 3, MAX_SEGMENTS);
         end else begin
            fill = $urandom_range(8, 1);
         end
         mix  = $urandom_range(40, 15);
         sent += 1 + fill + mix;
         repeat (fill) send_item(next_insert());
         repeat (mix) send_item(next_mixed());
      end
   endtask

   initial begin
      xlate_rsp_type got;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.status       = rsp_chan.status;
            got.mapped_start = rsp_chan.mapped_start;
            got.mapped_end   = rsp_chan.mapped_end;
            board.check_result(got);
         end
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int unsigned idle_run;
      idle_run = 0;
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_run = 0;
         end else begin
            idle_run++;
         end
      end
      $display("no beat on either channel for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_chan.valid           <= 1'b0;
      req_chan.action          <= ACT_INSERT;
      req_chan.first_offset    <= '0;
      req_chan.first_valid     <= 1'b0;
      req_chan.second_offset   <= '0;
      req_chan.second_valid    <= 1'b0;
      req_chan.document_offset <= '0;
      req_chan.document_valid  <= 1'b0;
      reset                    <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      recv_idle_pct = 50;
      run_directed();
      run_random(RANDOM_ITEMS / 3, 1'b1);

      // long output stall while requests keep coming
      send_idle_pct   = 50;
      recv_idle_pct   = 33;
      rsp_hold_cycles = HOLD_CYCLES;
      run_random(RANDOM_ITEMS / 3, 1'b0);

      // let everything drain before the no-idle stretch
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 1'b0);

      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d requests, %0d results checked, %0d inserts taken, %0d table-full refusals",
               board.requests, board.checked, board.ok_count[ACT_INSERT], board.full_count);
      $display("run: hits forward %0d, range %0d, reverse %0d; clears %0d; %0d errors",
               board.ok_count[ACT_MAP], board.ok_count[ACT_RANGE], board.ok_count[ACT_REVERSE],
               board.ok_count[ACT_CLEAR], board.errors);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
